@@ rtl/core/iph_pkg.sv @@
// Shared types and constants for the IPv4 header parser.
`timescale 1ns / 1ps
package iph_pkg;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_VERSION = 2'd1;
    localparam logic [1:0] ST_PARSE_ERR   = 2'd2;

    localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLASS_ICMP    = 2'd1;
    localparam logic [1:0] CLASS_TCP     = 2'd2;
    localparam logic [1:0] CLASS_UDP     = 2'd3;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [5:0]  LAST_IDX      = 6'd59;
    localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

    // byte index within the header, from the front part
    localparam logic [5:0] IDX_VER   = 6'd0;
    localparam logic [5:0] IDX_TL_HI = 6'd2;
    localparam logic [5:0] IDX_TL_LO = 6'd3;
    localparam logic [5:0] IDX_TTL   = 6'd8;
    localparam logic [5:0] IDX_PROTO = 6'd9;
    localparam logic [5:0] IDX_CK_HI = 6'd10;
    localparam logic [5:0] IDX_CK_LO = 6'd11;
    localparam logic [5:0] IDX_SRC0  = 6'd12;
    localparam logic [5:0] IDX_SRC3  = 6'd15;
    localparam logic [5:0] IDX_DST0  = 6'd16;
    localparam logic [5:0] IDX_DST3  = 6'd19;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [15:0] rem;
        logic [5:0]  idx;
    } tag_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  version;
        logic [5:0]  header_len;
        logic [15:0] tot_len;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [1:0]  protocol_class;
        logic [15:0] header_checksum;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } res_t;

    function automatic logic [1:0] class_of(input logic [7:0] proto);
        logic [1:0] c;
        c = CLASS_UNKNOWN;
        if (proto == PROTO_ICMP) c = CLASS_ICMP;
        else if (proto == PROTO_TCP) c = CLASS_TCP;
        else if (proto == PROTO_UDP) c = CLASS_UDP;
        return c;
    endfunction

endpackage

@@ rtl/core/iph_front.sv @@
// Front part: accepts bytes, tags them with their header index, queues them.
`timescale 1ns / 1ps
module iph_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      data_byte,
    input  logic            header_start,
    input  logic [15:0]     pkt_left,
    output logic            q_valid,
    input  logic            q_take,
    output iph_pkg::tag_t   q_item
);
    import iph_pkg::*;

    logic [5:0] cnt_reg, cnt_next;
    logic       active_reg, active_next;
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    tag_t       mem [2];
    tag_t       item;
    logic       accept;
    logic       enq;
    logic       deq;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];
    assign accept  = push && !full;
    // bytes outside any possible header are dropped here
    assign enq     = accept && (header_start || active_reg);
    assign deq     = q_take && q_valid;

    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        item.data   = data_byte;
        item.start  = header_start;
        item.rem    = pkt_left;
        item.idx    = header_start ? 6'd0 : cnt_reg;
        if (accept)
        begin
            if (header_start)
            begin
                cnt_next    = 6'd1;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                cnt_next    = cnt_reg + 6'd1;
                active_next = (cnt_reg != LAST_IDX);
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (enq)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (deq)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 6'd0;
            active_reg <= 1'b0;
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

endmodule

@@ rtl/core/iph_back.sv @@
// Back part: header checks, field capture, checksum, and the result queue.
`timescale 1ns / 1ps
module iph_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_take,
    input  iph_pkg::tag_t   in_item,
    output logic            empty,
    input  logic            pop,
    output iph_pkg::res_t   res_item
);
    import iph_pkg::*;

    logic        in_header_reg, in_header_next;
    logic [5:0]  hdr_len_reg, hdr_len_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [3:0]  version_reg, version_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] cksum_reg, cksum_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    res_t        mem [2];

    logic        process;
    logic        fin;
    logic        done;
    logic [1:0]  st;
    logic [16:0] raw_sum;
    logic        deq;
    res_t        res;

    assign process = in_valid && (count_reg != 2'd2);
    assign in_take = process;
    assign empty   = (count_reg == 2'd0);
    assign res_item = mem[rd_ptr_reg];
    assign deq     = pop && !empty;

    always_comb
    begin
        in_header_next = in_header_reg;
        hdr_len_next   = hdr_len_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        hold_next      = hold_reg;
        version_next   = version_reg;
        total_next     = total_reg;
        ttl_next       = ttl_reg;
        proto_next     = proto_reg;
        cksum_next     = cksum_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        fin            = 1'b0;
        done           = 1'b0;
        st             = ST_OK;
        raw_sum        = 17'd0;

        if (process && (in_item.start || in_header_reg))
        begin
            if (in_item.start)
            begin
                in_header_next = 1'b1;
                hdr_len_next   = 6'd0;
                remaining_next = in_item.rem;
                sum_next       = 16'd0;
                hold_next      = 8'd0;
                version_next   = 4'd0;
                total_next     = 16'd0;
                ttl_next       = 8'd0;
                proto_next     = 8'd0;
                cksum_next     = 16'd0;
                src_next       = 32'd0;
                dst_next       = 32'd0;
            end

            if (in_item.idx == IDX_VER)
            begin
                if (remaining_next < MIN_HDR_BYTES)
                begin
                    fin  = 1'b1;
                    done = 1'b1;
                    st   = ST_PARSE_ERR;
                end
                else
                begin
                    version_next = in_item.data[7:4];
                    hdr_len_next = {in_item.data[3:0], 2'b00};
                    if (in_item.data[7:4] != IP_VERSION)
                    begin
                        fin  = 1'b1;
                        done = 1'b1;
                        st   = ST_BAD_VERSION;
                    end
                    else if (in_item.data[3:0] < MIN_IHL ||
                             remaining_next < {10'd0, in_item.data[3:0], 2'b00})
                    begin
                        fin  = 1'b1;
                        done = 1'b1;
                        st   = ST_PARSE_ERR;
                    end
                end
            end

            if (!done)
            begin
                // even bytes are word high halves; odd bytes close an end-around add
                if (!in_item.idx[0])
                begin
                    hold_next = in_item.data;
                end
                else
                begin
                    raw_sum  = {1'b0, sum_next} + {1'b0, hold_reg, in_item.data};
                    sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
                end

                case (in_item.idx)
                    IDX_TL_HI: total_next = {in_item.data, 8'd0};
                    IDX_TL_LO: total_next = {total_reg[15:8], in_item.data};
                    IDX_TTL:   ttl_next   = in_item.data;
                    IDX_PROTO: proto_next = in_item.data;
                    IDX_CK_HI: cksum_next = {in_item.data, 8'd0};
                    IDX_CK_LO: cksum_next = {cksum_reg[15:8], in_item.data};
                    default:
                    begin
                        if (in_item.idx >= IDX_SRC0 && in_item.idx <= IDX_SRC3)
                        begin
                            src_next = {src_reg[23:0], in_item.data};
                        end
                        else if (in_item.idx >= IDX_DST0 && in_item.idx <= IDX_DST3)
                        begin
                            dst_next = {dst_reg[23:0], in_item.data};
                        end
                    end
                endcase

                if (in_item.idx == IDX_TL_LO &&
                    (total_next < {10'd0, hdr_len_next} || total_next > remaining_next))
                begin
                    fin  = 1'b1;
                    done = 1'b1;
                    st   = ST_PARSE_ERR;
                end
                else if (({1'b0, in_item.idx} + 7'd1) >= {1'b0, hdr_len_next})
                begin
                    fin  = 1'b1;
                    done = 1'b1;
                    st   = (sum_next == SUM_GOOD) ? ST_OK : ST_PARSE_ERR;
                end
            end

            if (fin)
            begin
                in_header_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.status          = st;
        res.version         = version_next;
        res.header_len      = hdr_len_next;
        res.tot_len         = total_next;
        res.ttl             = ttl_next;
        res.protocol        = proto_next;
        res.protocol_class  = (st == ST_OK) ? class_of(proto_next) : CLASS_UNKNOWN;
        res.header_checksum = cksum_next;
        res.src_ip          = src_next;
        res.dst_ip          = dst_next;
    end

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (fin)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (deq)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (fin && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (deq && !fin)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b0;
            hdr_len_reg   <= 6'd0;
            remaining_reg <= 16'd0;
            sum_reg       <= 16'd0;
            hold_reg      <= 8'd0;
            version_reg   <= 4'd0;
            total_reg     <= 16'd0;
            ttl_reg       <= 8'd0;
            proto_reg     <= 8'd0;
            cksum_reg     <= 16'd0;
            src_reg       <= 32'd0;
            dst_reg       <= 32'd0;
            count_reg     <= 2'd0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
        end
        else
        begin
            in_header_reg <= in_header_next;
            hdr_len_reg   <= hdr_len_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            hold_reg      <= hold_next;
            version_reg   <= version_next;
            total_reg     <= total_next;
            ttl_reg       <= ttl_next;
            proto_reg     <= proto_next;
            cksum_reg     <= cksum_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            count_reg     <= count_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

endmodule

@@ rtl/core/ipv4_header_parser.sv @@
// IPv4 header parser top level: byte front end, two-entry queue, parse back end.
// Throughput: one header byte per cycle while the result queue has room.
// A header's last byte passes through a front queue entry, then one back-end step
// that writes its result into the result queue, where it shows on the output side.
// With two results waiting the back end stalls; full rises once the front queue fills.
// Reset (rst_n low, asynchronous) empties both queues and leaves the parser idle.
`timescale 1ns / 1ps
module ipv4_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        header_start,
    input  logic [15:0] pkt_left,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [3:0]  version,
    output logic [5:0]  header_len,
    output logic [15:0] tot_len,
    output logic [7:0]  ttl,
    output logic [7:0]  protocol,
    output logic [1:0]  protocol_class,
    output logic [15:0] header_checksum,
    output logic [31:0] src_ip,
    output logic [31:0] dst_ip
);
    import iph_pkg::*;

    logic q_valid;
    logic q_take;
    tag_t q_item;
    res_t res_item;

    iph_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .header_start (header_start),
        .pkt_left     (pkt_left),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_item       (q_item)
    );

    iph_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_take  (q_take),
        .in_item  (q_item),
        .empty    (empty),
        .pop      (pop),
        .res_item (res_item)
    );

    assign status          = res_item.status;
    assign version         = res_item.version;
    assign header_len      = res_item.header_len;
    assign tot_len         = res_item.tot_len;
    assign ttl             = res_item.ttl;
    assign protocol        = res_item.protocol;
    assign protocol_class  = res_item.protocol_class;
    assign header_checksum = res_item.header_checksum;
    assign src_ip          = res_item.src_ip;
    assign dst_ip          = res_item.dst_ip;

endmodule
